// ----- hw/rtl/wpc_pkg.sv -----
// wpc_pkg: shared types, codes and constants of the WHOIS payload classifier.
// No dependencies; used by every module of the block except wpc_checker.
package wpc_pkg;

    // Default width of the byte counter and line-end positions
    localparam int LENGTH_BITS_DEF = 16;

    // Configuration register widths
    localparam int PORT_W  = 16;
    localparam int LEN16_W = 16;
    localparam int LB_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [PORT_W-1:0]  SERVICE_PORT_RST     = 16'd43;
    localparam logic [LEN16_W-1:0] MIN_RESPONSE_LEN_RST = 16'd50;
    localparam logic [LB_W-1:0]    MIN_LINE_BREAKS_RST  = 8'd2;
    localparam logic [LEN16_W-1:0] FIRST_LINE_CAP_RST   = 16'd64;

    // Register indexes on the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERVICE_PORT     = 3'd0,
        CFG_MIN_RESPONSE_LEN = 3'd1,
        CFG_MIN_LINE_BREAKS  = 3'd2,
        CFG_FIRST_LINE_CAP   = 3'd3
    } cfg_idx_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [PORT_W-1:0]  service_port;
        logic [LEN16_W-1:0] min_response_len;
        logic [LB_W-1:0]    min_line_breaks;
        logic [LEN16_W-1:0] first_line_cap;
    } cfg_t;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_QUERY    = 2'd1,
        VERDICT_RESPONSE = 2'd2
    } verdict_t;

    localparam int CONF_W = 7;
    localparam logic [CONF_W-1:0] CONF_NONE     = 7'd0;
    localparam logic [CONF_W-1:0] CONF_QUERY    = 7'd75;
    localparam logic [CONF_W-1:0] CONF_RESPONSE = 7'd40;

    // Character codes
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7E;

    localparam logic [7:0] LF_COUNT_MAX = 8'hFF;

    // Printable text byte: space through tilde, or tab
    function automatic logic is_printable(input logic [7:0] b);
        return (b inside {[PRINT_LO:PRINT_HI]}) || (b == CHAR_TAB);
    endfunction

endpackage

// ----- hw/rtl/wpc_cfg_regs.sv -----
// wpc_cfg_regs: the four configuration registers behind the plain write port.
// Depends on wpc_pkg.
module wpc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output wpc_pkg::cfg_t                      cfg
);

    wpc_pkg::cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.service_port     <= wpc_pkg::SERVICE_PORT_RST;
            cfg_reg.min_response_len <= wpc_pkg::MIN_RESPONSE_LEN_RST;
            cfg_reg.min_line_breaks  <= wpc_pkg::MIN_LINE_BREAKS_RST;
            cfg_reg.first_line_cap   <= wpc_pkg::FIRST_LINE_CAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wpc_pkg::CFG_SERVICE_PORT:
                    cfg_reg.service_port <= cfg_wdata[wpc_pkg::PORT_W-1:0];
                wpc_pkg::CFG_MIN_RESPONSE_LEN:
                    cfg_reg.min_response_len <= cfg_wdata[wpc_pkg::LEN16_W-1:0];
                wpc_pkg::CFG_MIN_LINE_BREAKS:
                    cfg_reg.min_line_breaks <= cfg_wdata[wpc_pkg::LB_W-1:0];
                wpc_pkg::CFG_FIRST_LINE_CAP:
                    cfg_reg.first_line_cap <= cfg_wdata[wpc_pkg::LEN16_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/wpc_line_tracker.sv -----
// wpc_line_tracker: per-packet byte tracking (length, LF count, printability,
// first CRLF and first LF). Depends on wpc_pkg.
module wpc_line_tracker #(
    parameter int LENGTH_BITS = wpc_pkg::LENGTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,       // item leaves the input register
    input  logic                          take,       // item carries a byte
    input  logic                          pkt_end,    // item ends the packet
    input  logic [7:0]                    data_byte,
    input  logic [wpc_pkg::LEN16_W-1:0]   first_line_cap,
    output logic [LENGTH_BITS-1:0]        len,        // length including this byte
    output logic [LENGTH_BITS-1:0]        eol_pos,
    output logic                          line_ok,
    output logic                          capped_ok,
    output logic [7:0]                    lf_count
);

    localparam int CW = (LENGTH_BITS > wpc_pkg::LEN16_W) ? LENGTH_BITS : wpc_pkg::LEN16_W;

    logic [LENGTH_BITS-1:0] byte_count_reg, byte_count_upd, byte_count_next;
    logic [7:0]             lf_count_reg, lf_count_upd, lf_count_next;
    logic                   all_pr_reg, all_pr_upd, all_pr_next;
    logic                   capped_pr_reg, capped_pr_upd, capped_pr_next;
    logic                   prev_cr_reg, prev_cr_upd, prev_cr_next;
    logic                   pr_before_cr_reg, pr_before_cr_upd, pr_before_cr_next;
    logic                   lone_found_reg, lone_found_upd, lone_found_next;
    logic [LENGTH_BITS-1:0] lone_pos_reg, lone_pos_upd, lone_pos_next;
    logic                   lone_ok_reg, lone_ok_upd, lone_ok_next;
    logic                   crlf_found_reg, crlf_found_upd, crlf_found_next;
    logic [LENGTH_BITS-1:0] crlf_pos_reg, crlf_pos_upd, crlf_pos_next;
    logic                   crlf_ok_reg, crlf_ok_upd, crlf_ok_next;

    logic pr;
    logic is_lf;
    logic in_cap;

    assign pr     = wpc_pkg::is_printable(data_byte);
    assign is_lf  = (data_byte == wpc_pkg::CHAR_LF);
    assign in_cap = (CW'(byte_count_reg) < CW'(first_line_cap));

    // State after this beat's byte
    always_comb
    begin
        byte_count_upd   = byte_count_reg;
        lf_count_upd     = lf_count_reg;
        all_pr_upd       = all_pr_reg;
        capped_pr_upd    = capped_pr_reg;
        prev_cr_upd      = prev_cr_reg;
        pr_before_cr_upd = pr_before_cr_reg;
        lone_found_upd   = lone_found_reg;
        lone_pos_upd     = lone_pos_reg;
        lone_ok_upd      = lone_ok_reg;
        crlf_found_upd   = crlf_found_reg;
        crlf_pos_upd     = crlf_pos_reg;
        crlf_ok_upd      = crlf_ok_reg;
        if (take)
        begin
            if (is_lf)
            begin
                if (prev_cr_reg && !crlf_found_reg && (byte_count_reg != '0))
                begin
                    crlf_found_upd = 1'b1;
                    crlf_pos_upd   = byte_count_reg - LENGTH_BITS'(1);
                    crlf_ok_upd    = pr_before_cr_reg;
                end
                if (!lone_found_reg)
                begin
                    lone_found_upd = 1'b1;
                    lone_pos_upd   = byte_count_reg;
                    lone_ok_upd    = all_pr_reg;
                end
                if (lf_count_reg != wpc_pkg::LF_COUNT_MAX)
                    lf_count_upd = lf_count_reg + 8'd1;
            end
            pr_before_cr_upd = all_pr_reg;
            if (in_cap && !pr)
                capped_pr_upd = 1'b0;
            if (!pr)
                all_pr_upd = 1'b0;
            prev_cr_upd = (data_byte == wpc_pkg::CHAR_CR);
            if (byte_count_reg != '1)
                byte_count_upd = byte_count_reg + LENGTH_BITS'(1);
        end
    end

    // Line end: first CRLF, else first LF, else the length
    always_comb
    begin
        if (crlf_found_upd)
        begin
            eol_pos = crlf_pos_upd;
            line_ok = crlf_ok_upd;
        end
        else if (lone_found_upd)
        begin
            eol_pos = lone_pos_upd;
            line_ok = lone_ok_upd;
        end
        else
        begin
            eol_pos = byte_count_upd;
            line_ok = all_pr_upd;
        end
    end

    assign len       = byte_count_upd;
    assign capped_ok = capped_pr_upd;
    assign lf_count  = lf_count_upd;

    // Advance on each beat, clear after the packet's last beat
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        lf_count_next     = lf_count_reg;
        all_pr_next       = all_pr_reg;
        capped_pr_next    = capped_pr_reg;
        prev_cr_next      = prev_cr_reg;
        pr_before_cr_next = pr_before_cr_reg;
        lone_found_next   = lone_found_reg;
        lone_pos_next     = lone_pos_reg;
        lone_ok_next      = lone_ok_reg;
        crlf_found_next   = crlf_found_reg;
        crlf_pos_next     = crlf_pos_reg;
        crlf_ok_next      = crlf_ok_reg;
        if (step && pkt_end)
        begin
            byte_count_next   = '0;
            lf_count_next     = '0;
            all_pr_next       = 1'b1;
            capped_pr_next    = 1'b1;
            prev_cr_next      = 1'b0;
            pr_before_cr_next = 1'b1;
            lone_found_next   = 1'b0;
            lone_pos_next     = '0;
            lone_ok_next      = 1'b0;
            crlf_found_next   = 1'b0;
            crlf_pos_next     = '0;
            crlf_ok_next      = 1'b0;
        end
        else if (step)
        begin
            byte_count_next   = byte_count_upd;
            lf_count_next     = lf_count_upd;
            all_pr_next       = all_pr_upd;
            capped_pr_next    = capped_pr_upd;
            prev_cr_next      = prev_cr_upd;
            pr_before_cr_next = pr_before_cr_upd;
            lone_found_next   = lone_found_upd;
            lone_pos_next     = lone_pos_upd;
            lone_ok_next      = lone_ok_upd;
            crlf_found_next   = crlf_found_upd;
            crlf_pos_next     = crlf_pos_upd;
            crlf_ok_next      = crlf_ok_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            lf_count_reg     <= '0;
            all_pr_reg       <= 1'b1;
            capped_pr_reg    <= 1'b1;
            prev_cr_reg      <= 1'b0;
            pr_before_cr_reg <= 1'b1;
            lone_found_reg   <= 1'b0;
            lone_pos_reg     <= '0;
            lone_ok_reg      <= 1'b0;
            crlf_found_reg   <= 1'b0;
            crlf_pos_reg     <= '0;
            crlf_ok_reg      <= 1'b0;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            lf_count_reg     <= lf_count_next;
            all_pr_reg       <= all_pr_next;
            capped_pr_reg    <= capped_pr_next;
            prev_cr_reg      <= prev_cr_next;
            pr_before_cr_reg <= pr_before_cr_next;
            lone_found_reg   <= lone_found_next;
            lone_pos_reg     <= lone_pos_next;
            lone_ok_reg      <= lone_ok_next;
            crlf_found_reg   <= crlf_found_next;
            crlf_pos_reg     <= crlf_pos_next;
            crlf_ok_reg      <= crlf_ok_next;
        end
    end

endmodule

// ----- hw/rtl/wpc_verdict.sv -----
// wpc_verdict: packet classification and the result register on the master side.
// Depends on wpc_pkg.
module wpc_verdict #(
    parameter int LENGTH_BITS = wpc_pkg::LENGTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,       // packet-ending beat advances
    input  logic                          is_tcp,
    input  logic [wpc_pkg::PORT_W-1:0]    pkt_port,
    input  wpc_pkg::cfg_t                 cfg,
    input  logic [LENGTH_BITS-1:0]        len,
    input  logic [LENGTH_BITS-1:0]        eol_pos,
    input  logic                          line_ok,
    input  logic                          capped_ok,
    input  logic [7:0]                    lf_count,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [15:0]                   m_tdata,    // verdict[1:0], confidence[8:2]
    output logic                          out_stall   // result held, not taken
);

    localparam int CW = (LENGTH_BITS > wpc_pkg::LEN16_W) ? LENGTH_BITS : wpc_pkg::LEN16_W;

    wpc_pkg::verdict_t               verdict_next, verdict_reg;
    logic [wpc_pkg::CONF_W-1:0]      conf_next, conf_reg;
    logic                            out_valid_reg, out_valid_next;
    logic                            cap_pr;
    logic                            le_nonzero;

    assign le_nonzero = (eol_pos != '0);
    assign cap_pr     = (CW'(eol_pos) <= CW'(cfg.first_line_cap)) ? line_ok : capped_ok;

    // Classification of the finished packet
    always_comb
    begin
        verdict_next = wpc_pkg::VERDICT_NONE;
        conf_next    = wpc_pkg::CONF_NONE;
        if (is_tcp && (len != '0))
        begin
            if (pkt_port == cfg.service_port)
            begin
                if (le_nonzero && line_ok)
                begin
                    verdict_next = wpc_pkg::VERDICT_QUERY;
                    conf_next    = wpc_pkg::CONF_QUERY;
                end
            end
            else if (le_nonzero && (cfg.first_line_cap != '0) && cap_pr &&
                     (CW'(len) >= CW'(cfg.min_response_len)) &&
                     (lf_count >= cfg.min_line_breaks))
            begin
                verdict_next = wpc_pkg::VERDICT_RESPONSE;
                conf_next    = wpc_pkg::CONF_RESPONSE;
            end
        end
    end

    // Result valid: set on load, cleared once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict_next;
            conf_reg    <= conf_next;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, conf_reg, verdict_reg};
    assign out_stall = out_valid_reg && !m_tready;

endmodule

// ----- hw/rtl/whois_payload_classifier_top.sv -----
// whois_payload_classifier_top: stream-in bytes, stream-out one verdict per packet.
// Depends on wpc_pkg, wpc_cfg_regs, wpc_line_tracker and wpc_verdict.

// The block takes one payload byte per beat and sustains one beat per clock
// while no verdict is stuck at the master side; each beat sits in the input
// register, where the per-byte flag and counter update runs, and the verdict
// of a packet is loaded into the result register when its ending beat leaves
// the input register, and shows on the master side from then on. Only the
// ending beat (tlast or the empty-packet flag in tuser) waits for the result
// register; other beats keep flowing while an earlier verdict is still pending.
// Configuration writes take effect on the next clock and belong between
// packets. There is no memory and no clearing pass after reset.
module whois_payload_classifier_top #(
    parameter int LENGTH_BITS = wpc_pkg::LENGTH_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // data_byte[7:0], pkt_port[23:8]
    input  logic                              s_axis_tlast,  // last_byte
    input  logic [1:0]                        s_axis_tuser,  // empty_packet[0], is_tcp[1]
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // verdict[1:0], confidence[8:2]
    // configuration
    input  logic                              cfg_we,
    input  logic [wpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    wpc_pkg::cfg_t cfg;

    logic                          in_valid_reg, in_valid_next;
    logic [7:0]                    in_byte_reg;
    logic [wpc_pkg::PORT_W-1:0]    in_port_reg;
    logic                          in_last_reg;
    logic                          in_empty_reg;
    logic                          in_tcp_reg;

    logic                          pkt_end;
    logic                          advance;
    logic                          s_fire;
    logic                          out_stall;

    logic [LENGTH_BITS-1:0]        len;
    logic [LENGTH_BITS-1:0]        eol_pos;
    logic                          line_ok;
    logic                          capped_ok;
    logic [7:0]                    lf_count;

    wpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input flow: an ending beat waits only when a verdict is stuck
    assign pkt_end       = in_last_reg || in_empty_reg;
    assign advance       = in_valid_reg && (!pkt_end || !out_stall);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Input beat register
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg  <= s_axis_tdata[7:0];
            in_port_reg  <= s_axis_tdata[23:8];
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser[0];
            in_tcp_reg   <= s_axis_tuser[1];
        end
    end

    wpc_line_tracker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .take           (!in_empty_reg),
        .pkt_end        (pkt_end),
        .data_byte      (in_byte_reg),
        .first_line_cap (cfg.first_line_cap),
        .len            (len),
        .eol_pos        (eol_pos),
        .line_ok        (line_ok),
        .capped_ok      (capped_ok),
        .lf_count       (lf_count)
    );

    wpc_verdict #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && pkt_end),
        .is_tcp     (in_tcp_reg),
        .pkt_port   (in_port_reg),
        .cfg        (cfg),
        .len        (len),
        .eol_pos    (eol_pos),
        .line_ok    (line_ok),
        .capped_ok  (capped_ok),
        .lf_count   (lf_count),
        .m_tready   (m_axis_tready),
        .m_tvalid   (m_axis_tvalid),
        .m_tdata    (m_axis_tdata),
        .out_stall  (out_stall)
    );

endmodule

// ----- hw/rtl/wpc_checker.sv -----
// wpc_checker: port-level assertions for whois_payload_classifier_top.
// Depends on whois_payload_classifier_top (bound below); no package use.
module wpc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tlast,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata
);

    // A held result keeps its value until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Verdict and confidence always come as a matching pair
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[1:0] == 2'd0 && m_axis_tdata[8:2] == 7'd0) ||
            (m_axis_tdata[1:0] == 2'd1 && m_axis_tdata[8:2] == 7'd75) ||
            (m_axis_tdata[1:0] == 2'd2 && m_axis_tdata[8:2] == 7'd40))
        else $error("verdict and confidence disagree");

    // A fresh result must trace back to an accepted packet-ending beat
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser[0]), 2))
        else $error("result without a packet-ending beat");

    // Input back-pressure only while a result is stuck at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

endmodule

bind whois_payload_classifier_top wpc_checker u_wpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/whois_payload_classifier_top_tb.sv -----
// whois_payload_classifier_top_tb: self-checking bench for the WHOIS payload classifier.
// Streams payload bytes, predicts one verdict per packet and compares it with the result beats.
// Depends on wpc_pkg and whois_payload_classifier_top.
`timescale 1ns / 100ps

module whois_payload_classifier_top_tb;

    localparam int LEN_W         = wpc_pkg::LENGTH_BITS_DEF;
    localparam int CFG_REG_COUNT = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 220;
    localparam int LONG_TEXT     = 20;
    localparam int LONG_LF       = 260;

    // One input beat, unpacked from the slave side
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        empty_packet;
        logic [15:0] pkt_port;
        logic        is_tcp;
    } beat_t;

    typedef struct packed {
        wpc_pkg::verdict_t          verdict;
        logic [wpc_pkg::CONF_W-1:0] confidence;
    } verdict_rec_t;

    // Tracks line ends and printability of the packet in flight, queues the verdicts
    class payload_verdict_board;
        logic [wpc_pkg::PORT_W-1:0]  service_port;
        logic [wpc_pkg::LEN16_W-1:0] min_response_len;
        logic [wpc_pkg::LB_W-1:0]    min_line_breaks;
        logic [wpc_pkg::LEN16_W-1:0] first_line_cap;

        logic [LEN_W-1:0] byte_count;
        logic [7:0]       lf_count;
        logic             all_printable;
        logic             capped_printable;
        logic             prev_cr;
        logic             ok_before_cr;
        logic             lf_found;
        int unsigned      lf_pos;
        logic             lf_ok;
        logic             crlf_found;
        int unsigned      crlf_pos;
        logic             crlf_ok;

        verdict_rec_t     expected_verdicts[$];
        int unsigned      failures;

        function new();
            service_port     = wpc_pkg::SERVICE_PORT_RST;
            min_response_len = wpc_pkg::MIN_RESPONSE_LEN_RST;
            min_line_breaks  = wpc_pkg::MIN_LINE_BREAKS_RST;
            first_line_cap   = wpc_pkg::FIRST_LINE_CAP_RST;
            failures         = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_count       = '0;
            lf_count         = '0;
            all_printable    = 1'b1;
            capped_printable = 1'b1;
            prev_cr          = 1'b0;
            ok_before_cr     = 1'b1;
            lf_found         = 1'b0;
            lf_pos           = 0;
            lf_ok            = 1'b0;
            crlf_found       = 1'b0;
            crlf_pos         = 0;
            crlf_ok          = 1'b0;
        endfunction

        // Register write; unused indexes are dropped, data masked to the register
        function void set_reg(input logic [wpc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [wpc_pkg::CFG_DATA_W-1:0] val);
            case (wpc_pkg::cfg_idx_t'(idx))
                wpc_pkg::CFG_SERVICE_PORT:
                    service_port = val[wpc_pkg::PORT_W-1:0];
                wpc_pkg::CFG_MIN_RESPONSE_LEN:
                    min_response_len = val[wpc_pkg::LEN16_W-1:0];
                wpc_pkg::CFG_MIN_LINE_BREAKS:
                    min_line_breaks = val[wpc_pkg::LB_W-1:0];
                wpc_pkg::CFG_FIRST_LINE_CAP:
                    first_line_cap = val[wpc_pkg::LEN16_W-1:0];
                default: ;
            endcase
        endfunction

        // Accepted slave beat: update flags, and on a packet end queue the verdict
        function void absorb_beat(input beat_t bt);
            int unsigned  idx;
            logic         printable;
            int unsigned  eol_pos;
            logic         line_ok;
            int unsigned  checked;
            logic         checked_ok;
            verdict_rec_t rec;

            if (!bt.empty_packet) begin
                idx = byte_count;
                printable = (bt.data_byte >= wpc_pkg::PRINT_LO &&
                             bt.data_byte <= wpc_pkg::PRINT_HI) ||
                            (bt.data_byte == wpc_pkg::CHAR_TAB);
                if (bt.data_byte == wpc_pkg::CHAR_LF) begin
                    if (prev_cr && !crlf_found && idx > 0) begin
                        crlf_found = 1'b1;
                        crlf_pos   = idx - 1;
                        crlf_ok    = ok_before_cr;
                    end
                    if (!lf_found) begin
                        lf_found = 1'b1;
                        lf_pos   = idx;
                        lf_ok    = all_printable;
                    end
                    if (lf_count != wpc_pkg::LF_COUNT_MAX)
                        lf_count = lf_count + 8'd1;
                end
                ok_before_cr = all_printable;
                if (idx < first_line_cap && !printable)
                    capped_printable = 1'b0;
                if (!printable)
                    all_printable = 1'b0;
                prev_cr = (bt.data_byte == wpc_pkg::CHAR_CR);
                if (byte_count != '1)
                    byte_count = byte_count + 1'b1;
            end
            if (!(bt.last_byte || bt.empty_packet))
                return;

            // line end: first CRLF, else first LF, else the whole payload
            if (crlf_found) begin
                eol_pos = crlf_pos;
                line_ok = crlf_ok;
            end else if (lf_found) begin
                eol_pos = lf_pos;
                line_ok = lf_ok;
            end else begin
                eol_pos = byte_count;
                line_ok = all_printable;
            end

            rec.verdict    = wpc_pkg::VERDICT_NONE;
            rec.confidence = wpc_pkg::CONF_NONE;
            if (bt.is_tcp && byte_count != '0) begin
                if (bt.pkt_port == service_port) begin
                    if (eol_pos > 0 && line_ok) begin
                        rec.verdict    = wpc_pkg::VERDICT_QUERY;
                        rec.confidence = wpc_pkg::CONF_QUERY;
                    end
                end else begin
                    checked    = (eol_pos < first_line_cap) ? eol_pos : first_line_cap;
                    checked_ok = (eol_pos <= first_line_cap) ? line_ok : capped_printable;
                    if (checked > 0 && checked_ok && byte_count >= min_response_len &&
                        lf_count >= min_line_breaks) begin
                        rec.verdict    = wpc_pkg::VERDICT_RESPONSE;
                        rec.confidence = wpc_pkg::CONF_RESPONSE;
                    end
                end
            end
            expected_verdicts.push_back(rec);
            clear_packet();
        endfunction

        // Accepted master beat against the oldest outstanding verdict
        function void check_verdict(input logic [15:0] word);
            verdict_rec_t               want;
            logic [1:0]                 got_verdict;
            logic [wpc_pkg::CONF_W-1:0] got_conf;

            got_verdict = word[1:0];
            got_conf    = word[2 +: wpc_pkg::CONF_W];
            if (expected_verdicts.size() == 0) begin
                $error("unexpected verdict beat: verdict %0d confidence %0d",
                       got_verdict, got_conf);
                failures++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (got_verdict != want.verdict) begin
                $error("verdict mismatch: expected %0d, actual %0d", want.verdict, got_verdict);
                failures++;
            end
            if (got_conf != want.confidence) begin
                $error("confidence mismatch: expected %0d, actual %0d",
                       want.confidence, got_conf);
                failures++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata = '0;   // data_byte[7:0], pkt_port[23:8]
    logic                           s_axis_tlast = 1'b0; // last_byte
    logic [1:0]                     s_axis_tuser = '0;   // empty_packet[0], is_tcp[1]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [15:0]                    m_axis_tdata;        // verdict[1:0], confidence[8:2]
    logic                           cfg_we = 1'b0;
    logic [wpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    payload_verdict_board sb;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_sent     = 0;
    int stall_cycles   = 0;

    whois_payload_classifier_top #(
        .LENGTH_BITS(LEN_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: results first, so a beat noted this edge is never matched this edge
    always @(posedge clk)
    begin
        beat_t seen;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_verdict(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                seen.data_byte    = s_axis_tdata[7:0];
                seen.pkt_port     = s_axis_tdata[23:8];
                seen.last_byte    = s_axis_tlast;
                seen.empty_packet = s_axis_tuser[0];
                seen.is_tcp       = s_axis_tuser[1];
                sb.absorb_beat(seen);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
        end
    end

    // Watchdog on cycles without any beat
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] text_char();
        if ($urandom_range(19) == 0)
            return wpc_pkg::CHAR_TAB;
        return 8'(wpc_pkg::PRINT_LO + $urandom_range(wpc_pkg::PRINT_HI - wpc_pkg::PRINT_LO));
    endfunction

    // Port that misses the service port by one bit, or anything
    function automatic logic [15:0] other_port();
        if ($urandom_range(9) < 3)
            return sb.service_port ^ (16'd1 << $urandom_range(15));
        return 16'($urandom_range(65535));
    endfunction

    // Present one beat, with random idle cycles before it
    task automatic send_beat(input beat_t bt);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bt.pkt_port, bt.data_byte};
        s_axis_tlast  <= bt.last_byte;
        s_axis_tuser  <= {bt.is_tcp, bt.empty_packet};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Payload bytes, closed by tlast or by a trailing empty-packet beat
    task automatic send_packet(input logic [7:0] body[$], input logic [15:0] port,
                               input logic tcp, input logic end_empty);
        beat_t bt;
        bt.pkt_port     = port;
        bt.is_tcp       = tcp;
        bt.empty_packet = 1'b0;
        foreach (body[i]) begin
            bt.data_byte = body[i];
            bt.last_byte = (i == body.size() - 1) && !end_empty;
            send_beat(bt);
        end
        if (end_empty || body.size() == 0) begin
            bt.data_byte    = 8'($urandom_range(255));
            bt.last_byte    = 1'($urandom_range(1));
            bt.empty_packet = 1'b1;
            send_beat(bt);
        end
    endtask

    // Mostly line-shaped text (query or response like), some of it corrupted; rest noise
    task automatic random_packet();
        logic [7:0]  body[$];
        logic [15:0] port;
        int          shape;
        int          lines;
        int          len;
        int          term;

        shape = $urandom_range(99);
        if (shape < 80) begin
            lines = (shape < 40) ? 1 + $urandom_range(2) : 1 + $urandom_range(5);
            for (int l = 0; l < lines; l++) begin
                len = ($urandom_range(9) < 8) ? $urandom_range(24) : 25 + $urandom_range(55);
                repeat (len) body.push_back(text_char());
                term = $urandom_range(9);
                if (term < 5) begin
                    body.push_back(wpc_pkg::CHAR_CR);
                    body.push_back(wpc_pkg::CHAR_LF);
                end else if (term < 8) begin
                    body.push_back(wpc_pkg::CHAR_LF);
                end else if (term == 8) begin
                    body.push_back(wpc_pkg::CHAR_CR);
                end
            end
            if (body.size() > 0 && $urandom_range(4) == 0)
                body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
        end else begin
            repeat ($urandom_range(20)) body.push_back(8'($urandom_range(255)));
        end

        if (shape < 40)
            port = ($urandom_range(3) != 0) ? sb.service_port : other_port();
        else if (shape < 80)
            port = ($urandom_range(9) == 0) ? sb.service_port : other_port();
        else
            port = ($urandom_range(1) != 0) ? sb.service_port : other_port();
        send_packet(body, port, $urandom_range(9) != 0, $urandom_range(9) == 0);
    endtask

    // Short text line, CR, then enough LFs to pin the LF count
    task automatic long_packet(input logic to_service);
        logic [7:0] body[$];
        repeat (LONG_TEXT) body.push_back(text_char());
        body.push_back(wpc_pkg::CHAR_CR);
        repeat (LONG_LF) body.push_back(wpc_pkg::CHAR_LF);
        send_packet(body, to_service ? sb.service_port : sb.service_port + 16'd1,
                    1'b1, 1'b0);
    endtask

    task automatic write_reg(input logic [wpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wpc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stop sending and let every outstanding verdict drain
    task automatic quiesce();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [15:0] port, input logic [15:0] min_len,
                             input logic [7:0] min_lf, input logic [15:0] cap,
                             input int idle_pct, input int stall_pct, input int items);
        int                            first;
        int unsigned                   spare;
        logic [wpc_pkg::CFG_IDX_W-1:0] spare_idx;
        write_reg(wpc_pkg::CFG_SERVICE_PORT, port);
        write_reg(wpc_pkg::CFG_MIN_RESPONSE_LEN, min_len);
        write_reg(wpc_pkg::CFG_MIN_LINE_BREAKS, {8'($urandom_range(255)), min_lf});
        write_reg(wpc_pkg::CFG_FIRST_LINE_CAP, cap);
        spare     = CFG_REG_COUNT + $urandom_range(3);
        spare_idx = spare[wpc_pkg::CFG_IDX_W-1:0];
        write_reg(spare_idx, 16'($urandom));
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        first = items_sent;
        while (items_sent - first < items)
            random_packet();
        quiesce();
    endtask

    initial
    begin
        logic [7:0] no_bytes[$];

        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed packets on reset settings
        send_packet(no_bytes, wpc_pkg::SERVICE_PORT_RST, 1'b1, 1'b1);
        send_packet({8'h61, 8'h62, wpc_pkg::CHAR_CR, wpc_pkg::CHAR_LF},
                    wpc_pkg::SERVICE_PORT_RST, 1'b1, 1'b0);
        send_packet({wpc_pkg::CHAR_LF}, wpc_pkg::SERVICE_PORT_RST, 1'b1, 1'b0);
        send_packet({wpc_pkg::CHAR_TAB, wpc_pkg::PRINT_LO, wpc_pkg::PRINT_HI},
                    wpc_pkg::SERVICE_PORT_RST, 1'b1, 1'b1);
        send_packet({8'h1F, 8'h7F, 8'hFF, 8'h00}, wpc_pkg::SERVICE_PORT_RST, 1'b1, 1'b0);
        send_packet({8'h78, wpc_pkg::CHAR_LF}, wpc_pkg::SERVICE_PORT_RST, 1'b0, 1'b0);
        send_packet({wpc_pkg::CHAR_CR, wpc_pkg::CHAR_CR, wpc_pkg::CHAR_LF},
                    16'hFFFF, 1'b1, 1'b0);
        send_packet({8'h61, wpc_pkg::CHAR_LF, 8'h62}, wpc_pkg::SERVICE_PORT_RST, 1'b1, 1'b0);
        quiesce();

        // Random traffic over several settings and idle mixes
        run_phase(wpc_pkg::SERVICE_PORT_RST, 16'd20, 8'd2, 16'd16, 0, 0, PHASE_ITEMS);
        run_phase(16'hFFFF, 16'd0, 8'd0, 16'd1, 47, 0, PHASE_ITEMS);
        run_phase(16'h0000, 16'd40, 8'd3, 16'hFFFF, 0, 47, PHASE_ITEMS);
        run_phase(16'd12, 16'd1, 8'd0, 16'd0, 26, 26, PHASE_ITEMS);
        run_phase(wpc_pkg::SERVICE_PORT_RST, wpc_pkg::MIN_RESPONSE_LEN_RST,
                  wpc_pkg::MIN_LINE_BREAKS_RST, wpc_pkg::FIRST_LINE_CAP_RST,
                  47, 0, PHASE_ITEMS);
        run_phase(16'h8000, 16'd8, 8'd1, 16'd8, 0, 47, PHASE_ITEMS);

        // Saturated LF counter at the strictest LF threshold
        run_phase(16'h1234, 16'd100, 8'hFF, 16'hFFFF, 0, 0, 0);
        long_packet(1'b0);
        long_packet(1'b1);
        quiesce();

        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
